// ===== hw/rtl/dbah_pkg.sv =====
// dbah_pkg: shared types, constants and angle tables of the aim-height solver.
// Used by the channel interfaces, the CORDIC engine and the solver top level.
// No dependencies.
package dbah_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS          = 16;
    localparam int CORDIC_STAGES_DEF  = 24;
    localparam int COORD_W            = 32;
    localparam int ROUND_W            = 6;
    localparam int CW                 = 38;   // CORDIC datapath width, Q2.30 angles

    // Configuration port
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DRAG   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GRAV   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUNDS = 3'd4;

    localparam logic [15:0]        SPEED_RST  = 16'd3840;
    localparam logic [15:0]        DRAG_RST   = 16'd655;
    localparam logic [15:0]        GRAV_RST   = 16'd2509;
    localparam logic [15:0]        TOL_RST    = 16'd66;
    localparam logic [ROUND_W-1:0] ROUNDS_RST = 6'd20;

    // Q2.30 constants
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [30:0] CIRC_KINV = 31'd652032874;
    localparam logic [30:0] HYP_KINV  = 31'd1296540104;
    localparam logic [63:0] EXP_LIMIT = 64'd33 * 64'd744261118;
    localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

    // CORDIC modes
    localparam logic [1:0] CM_VEC = 2'd0;
    localparam logic [1:0] CM_ROT = 2'd1;
    localparam logic [1:0] CM_HYP = 2'd2;

    typedef struct packed {
        logic       start;
        logic [1:0] mode;
    } cordic_ctrl_t;

    localparam logic [31:0] CIRC_TAB [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

    localparam logic [31:0] HYP_TAB [11] = '{
        32'd0, 32'd589812981, 32'd274247418, 32'd134923406, 32'd67196451,
        32'd33565361, 32'd16778582, 32'd8388779, 32'd4194325, 32'd2097155,
        32'd1048576
    };

    // atanh(2^-i) in Q2.30; table for small i, 2^(30-i) beyond
    function automatic logic [31:0] hyp_angle(input logic [5:0] i);
        logic [31:0] a;
        if (i <= 6'd10)
            a = HYP_TAB[i[3:0]];
        else if (i <= 6'd30)
            a = 32'd1 << (6'd30 - i);
        else
            a = 32'd0;
        return a;
    endfunction

endpackage

// ===== hw/rtl/dbah_in_if.sv =====
// dbah_in_if: valid/ready channel carrying one target item.
// Depends on dbah_pkg for the coordinate width.
interface dbah_in_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dbah_pkg::COORD_W-1:0]    target_x;
    logic signed [dbah_pkg::COORD_W-1:0]    target_y;
    logic signed [dbah_pkg::COORD_W-1:0]    target_height;

    modport source (output valid, target_x, target_y, target_height, input ready);
    modport sink   (input valid, target_x, target_y, target_height, output ready);
endinterface

// ===== hw/rtl/dbah_out_if.sv =====
// dbah_out_if: valid/ready channel carrying one solution item.
// Depends on dbah_pkg for field widths.
interface dbah_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [dbah_pkg::COORD_W-1:0]    out_x;
    logic signed [dbah_pkg::COORD_W-1:0]    out_y;
    logic signed [dbah_pkg::COORD_W-1:0]    aim_height;
    logic        [31:0]                     flight_time;
    logic                                   converged;
    logic        [dbah_pkg::ROUND_W-1:0]    rounds_used;

    modport source (output valid, out_x, out_y, aim_height, flight_time, converged,
                    rounds_used, input ready);
    modport sink   (input valid, out_x, out_y, aim_height, flight_time, converged,
                    rounds_used, output ready);
endinterface

// ===== hw/rtl/drag_ballistic_aim_height_solver.sv =====
// Aim-height solver for a projectile with linear drag: top level and sequencer.
// Depends on dbah_pkg, dbah_in_if, dbah_out_if and dbah_cordic.
//
// One target item is taken at a time. Range is found by a 32-step bit-serial
// square root, then each correction round runs the shared CORDIC engine up to
// three times (atan2, skipped at the origin; sin/cos; exp), a 6-step ln2
// reduction and a 32-step restoring divide for flight time (the exp and the
// reduction are skipped on exponent overflow, the divide whenever the flight
// time saturates) and a handful of passes through one shared 32x32 multiplier.
// The finished item sits in an output register, and the next target is
// accepted while it waits.
module drag_ballistic_aim_height_solver #(
    parameter int CORDIC_STAGES = dbah_pkg::CORDIC_STAGES_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [dbah_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dbah_pkg::CFG_DATA_W-1:0]   cfg_data,
    dbah_in_if.sink                           target,
    dbah_out_if.source                        solution
);
    import dbah_pkg::*;

    localparam int NW    = 51;   // flight-time numerator
    localparam int DYW   = 60;   // height error
    localparam int U_LS  = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
    localparam int U_RS  = (FRAC_BITS > 14) ? FRAC_BITS - 14 : 0;
    localparam int TOL_L = (FRAC_BITS > 16) ? FRAC_BITS - 16 : 0;
    localparam int TOL_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
    localparam int M1_RS = 38 - FRAC_BITS;

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_SQA   = 5'd1;
    localparam logic [4:0] S_SQB   = 5'd2;
    localparam logic [4:0] S_SQC   = 5'd3;
    localparam logic [4:0] S_SQRT  = 5'd4;
    localparam logic [4:0] S_ATAN  = 5'd5;
    localparam logic [4:0] S_ATANW = 5'd6;
    localparam logic [4:0] S_SC    = 5'd7;
    localparam logic [4:0] S_SCW   = 5'd8;
    localparam logic [4:0] S_KR    = 5'd9;
    localparam logic [4:0] S_KR2   = 5'd10;
    localparam logic [4:0] S_RED   = 5'd11;
    localparam logic [4:0] S_EXP   = 5'd12;
    localparam logic [4:0] S_EXPW  = 5'd13;
    localparam logic [4:0] S_NUM   = 5'd14;
    localparam logic [4:0] S_KV    = 5'd15;
    localparam logic [4:0] S_KVC   = 5'd16;
    localparam logic [4:0] S_DCHK  = 5'd17;
    localparam logic [4:0] S_DCHK2 = 5'd18;
    localparam logic [4:0] S_DIV   = 5'd19;
    localparam logic [4:0] S_VS    = 5'd20;
    localparam logic [4:0] S_VT    = 5'd21;
    localparam logic [4:0] S_TT    = 5'd22;
    localparam logic [4:0] S_GW1   = 5'd23;
    localparam logic [4:0] S_GW2   = 5'd24;
    localparam logic [4:0] S_UPD   = 5'd25;
    localparam logic [4:0] S_AIM   = 5'd26;
    localparam logic [4:0] S_DONE  = 5'd27;

    // control state
    logic [4:0]         state_reg;
    logic               out_valid_reg;
    logic [15:0]        speed_reg, drag_reg, grav_reg, tol_reg;
    logic [ROUND_W-1:0] rounds_reg;

    // payload
    logic signed [31:0]   x_reg, y_reg, h_reg, aim_reg;
    logic [31:0]          ax_reg, ay_reg, r_reg, e_reg, dl_reg, t_reg;
    logic [63:0]          sq_reg, res_reg, prod_reg, glo_reg;
    logic [4:0]           cnt_reg;
    logic signed [CW-1:0] ang_reg, c_reg, s_reg;
    logic [35:0]          rem_reg;
    logic [5:0]           n_reg;
    logic [NW-1:0]        num_reg;
    logic [33:0]          d_reg;
    logic [40:0]          vt_reg;
    logic [15:0]          whi_reg;
    logic signed [DYW-1:0] dy_reg;
    logic [ROUND_W-1:0]   round_reg;
    logic                 conv_reg;
    logic signed [31:0]   ox_reg, oy_reg, oaim_reg;
    logic [31:0]          ot_reg;
    logic                 oconv_reg;
    logic [ROUND_W-1:0]   orounds_reg;

    // CORDIC engine
    cordic_ctrl_t         cctrl;
    logic signed [CW-1:0] cx0, cy0, cz0, cx, cy, cz;
    logic                 cdone;

    dbah_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (cctrl),
        .x0   (cx0),
        .y0   (cy0),
        .z0   (cz0),
        .done (cdone),
        .x    (cx),
        .y    (cy),
        .z    (cz)
    );

    logic                 accept_in, origin;
    logic [31:0]          mul_a, mul_b;
    logic [63:0]          bit_v, trial, res_next, u30;
    logic                 sq_ge;
    logic [35:0]          red_cmp, div_sh;
    logic signed [CW-1:0] e_sum;
    logic [6:0]           sh;
    logic [NW-1:0]        num_sh, num_next;
    logic                 cos_pos, div_ge;
    logic [31:0]          cos_op, abs_s;
    logic signed [CW-1:0] neg_s;
    logic [63:0]          gsum, w_full;
    logic signed [DYW-1:0] vt_s, gt_s, reach, dy_now, ady;
    logic signed [DYW:0]  aim_sum;
    logic signed [31:0]   aim_sat;
    logic [39:0]          tol_ext;
    logic                 conv_now;
    logic [ROUND_W-1:0]   lim;
    logic                 aim_over, aim_under;

    assign accept_in    = target.valid && target.ready;
    assign target.ready = (state_reg == S_IDLE);
    assign origin       = (r_reg == 32'd0) && (aim_reg == 32'sd0);

    // square root step
    always_comb
    begin
        bit_v    = 64'h4000_0000_0000_0000 >> {cnt_reg, 1'b0};
        trial    = res_reg + bit_v;
        sq_ge    = sq_reg >= trial;
        res_next = sq_ge ? (res_reg >> 1) + bit_v : res_reg >> 1;
    end

    // flight-time pieces
    always_comb
    begin
        u30      = (prod_reg << U_LS) >> U_RS;
        red_cmp  = {6'd0, LN2_Q30} << cnt_reg;
        e_sum    = cx + cy;
        sh       = {1'b0, n_reg} + 7'(FRAC_BITS);
        if (sh >= 7'd30)
            num_sh = {{(NW-32){1'b0}}, e_reg} << (sh - 7'd30);
        else
            num_sh = {{(NW-32){1'b0}}, e_reg} >> (7'd30 - sh);
        if (num_sh < (NW'(1) << FRAC_BITS))
            num_next = '0;
        else
            num_next = num_sh - (NW'(1) << FRAC_BITS);
        cos_pos  = !c_reg[CW-1] && (c_reg != '0);
        cos_op   = cos_pos ? c_reg[31:0] : 32'd0;
        div_sh   = {rem_reg[34:0], dl_reg[31]};
        div_ge   = div_sh >= {2'b00, d_reg};
    end

    // drop and aim update
    always_comb
    begin
        neg_s   = -s_reg;
        abs_s   = s_reg[CW-1] ? neg_s[31:0] : s_reg[31:0];
        w_full  = prod_reg >> FRAC_BITS;
        gsum    = {prod_reg[31:0], 32'd0} + glo_reg;
        vt_s    = $signed({{(DYW-41){1'b0}}, vt_reg});
        if (s_reg[CW-1])
            vt_s = -vt_s;
        gt_s    = $signed({{(DYW-55){1'b0}}, gsum[63:9]});
        reach   = vt_s - gt_s;
        dy_now  = DYW'(h_reg) - reach;
        aim_sum = (DYW+1)'(aim_reg) + (DYW+1)'(dy_reg);
        aim_over  = aim_sum > (DYW+1)'(32'sh7FFF_FFFF);
        aim_under = aim_sum < (DYW+1)'(32'sh8000_0000);
        if (aim_over)
            aim_sat = 32'sh7FFF_FFFF;
        else if (aim_under)
            aim_sat = 32'sh8000_0000;
        else
            aim_sat = aim_sum[31:0];
        ady      = dy_reg[DYW-1] ? -dy_reg : dy_reg;
        tol_ext  = ((40'(tol_reg) << TOL_L) + ((40'd1 << TOL_R) - 40'd1)) >> TOL_R;
        conv_now = ady < $signed({{(DYW-40){1'b0}}, tol_ext});
        lim      = (rounds_reg == '0) ? ROUND_W'(1) : rounds_reg;
    end

    // shared multiplier operands
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        unique case (state_reg)
            S_SQA:   begin mul_a = ax_reg;            mul_b = ax_reg;         end
            S_SQB:   begin mul_a = ay_reg;            mul_b = ay_reg;         end
            S_KR:    begin mul_a = 32'(drag_reg);     mul_b = r_reg;          end
            S_KV:    begin mul_a = 32'(drag_reg);     mul_b = 32'(speed_reg); end
            S_KVC:   begin mul_a = prod_reg[31:0];    mul_b = cos_op;         end
            S_VS:    begin mul_a = 32'(speed_reg);    mul_b = abs_s;          end
            S_VT:    begin mul_a = 32'(prod_reg >> M1_RS); mul_b = t_reg;     end
            S_TT:    begin mul_a = t_reg;             mul_b = t_reg;          end
            S_GW1:   begin mul_a = 32'(grav_reg);     mul_b = w_full[31:0];   end
            S_GW2:   begin mul_a = 32'(grav_reg);     mul_b = 32'(whi_reg);   end
            default: begin mul_a = 32'd0;             mul_b = 32'd0;          end
        endcase
    end

    // CORDIC launch
    always_comb
    begin
        cctrl.start = 1'b0;
        cctrl.mode  = CM_VEC;
        cx0 = '0;
        cy0 = '0;
        cz0 = '0;
        unique case (state_reg)
            S_ATAN:
            begin
                cctrl.start = !origin;
                cctrl.mode  = CM_VEC;
                cx0 = $signed({{(CW-32){1'b0}}, r_reg});
                cy0 = CW'(aim_reg);
            end
            S_SC:
            begin
                cctrl.start = 1'b1;
                cctrl.mode  = CM_ROT;
                cx0 = $signed({{(CW-31){1'b0}}, CIRC_KINV});
                cz0 = ang_reg;
            end
            S_EXP:
            begin
                cctrl.start = 1'b1;
                cctrl.mode  = CM_HYP;
                cx0 = $signed({{(CW-31){1'b0}}, HYP_KINV});
                cz0 = $signed({{(CW-36){1'b0}}, rem_reg});
            end
            default:
            begin
                cctrl.start = 1'b0;
            end
        endcase
    end

    // sequencer, output handshake and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            speed_reg     <= SPEED_RST;
            drag_reg      <= DRAG_RST;
            grav_reg      <= GRAV_RST;
            tol_reg       <= TOL_RST;
            rounds_reg    <= ROUNDS_RST;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SPEED:  speed_reg  <= cfg_data;
                    REG_DRAG:   drag_reg   <= cfg_data;
                    REG_GRAV:   grav_reg   <= cfg_data;
                    REG_TOL:    tol_reg    <= cfg_data;
                    REG_ROUNDS: rounds_reg <= cfg_data[ROUND_W-1:0];
                    default:    ;
                endcase
            end

            // output register: set on completion, cleared once taken
            if (state_reg == S_DONE && (!out_valid_reg || solution.ready))
                out_valid_reg <= 1'b1;
            else if (solution.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:  if (accept_in) state_reg <= S_SQA;
                S_SQA:   state_reg <= S_SQB;
                S_SQB:   state_reg <= S_SQC;
                S_SQC:   state_reg <= S_SQRT;
                S_SQRT:  if (cnt_reg == 5'd31) state_reg <= S_ATAN;
                S_ATAN:  state_reg <= origin ? S_SC : S_ATANW;
                S_ATANW: if (cdone) state_reg <= S_SC;
                S_SC:    state_reg <= S_SCW;
                S_SCW:   if (cdone) state_reg <= S_KR;
                S_KR:    state_reg <= S_KR2;
                S_KR2:   state_reg <= (u30 >= EXP_LIMIT) ? S_VS : S_RED;
                S_RED:   if (cnt_reg == 5'd0) state_reg <= S_EXP;
                S_EXP:   state_reg <= S_EXPW;
                S_EXPW:  if (cdone) state_reg <= S_NUM;
                S_NUM:   state_reg <= S_KV;
                S_KV:    state_reg <= S_KVC;
                S_KVC:   state_reg <= S_DCHK;
                S_DCHK:  state_reg <= S_DCHK2;
                S_DCHK2:
                begin
                    if (d_reg == '0 || num_reg >= {{(NW-42){1'b0}}, d_reg, 8'd0})
                        state_reg <= S_VS;
                    else
                        state_reg <= S_DIV;
                end
                S_DIV:   if (cnt_reg == 5'd31) state_reg <= S_VS;
                S_VS:    state_reg <= S_VT;
                S_VT:    state_reg <= S_TT;
                S_TT:    state_reg <= S_GW1;
                S_GW1:   state_reg <= S_GW2;
                S_GW2:   state_reg <= S_UPD;
                S_UPD:   state_reg <= S_AIM;
                S_AIM:   state_reg <= (conv_now || round_reg == lim) ? S_DONE : S_ATAN;
                S_DONE:  if (!out_valid_reg || solution.ready) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept_in)
                begin
                    x_reg     <= target.target_x;
                    y_reg     <= target.target_y;
                    h_reg     <= target.target_height;
                    aim_reg   <= target.target_height;
                    ax_reg    <= target.target_x[31] ? 32'(-target.target_x)
                                                     : 32'(target.target_x);
                    ay_reg    <= target.target_y[31] ? 32'(-target.target_y)
                                                     : 32'(target.target_y);
                    round_reg <= ROUND_W'(1);
                end
            end
            S_SQB:   sq_reg <= prod_reg;
            S_SQC:
            begin
                sq_reg  <= sq_reg + prod_reg;
                res_reg <= '0;
                cnt_reg <= '0;
            end
            S_SQRT:
            begin
                if (sq_ge)
                    sq_reg <= sq_reg - trial;
                res_reg <= res_next;
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                    r_reg <= res_next[31:0];
            end
            S_ATAN:  if (origin) ang_reg <= '0;
            S_ATANW: if (cdone) ang_reg <= cz;
            S_SCW:
            begin
                if (cdone)
                begin
                    c_reg <= cx;
                    s_reg <= cy;
                end
            end
            S_KR2:
            begin
                if (u30 >= EXP_LIMIT)
                    t_reg <= TIME_MAX;
                rem_reg <= u30[35:0];
                n_reg   <= '0;
                cnt_reg <= 5'd5;
            end
            S_RED:
            begin
                if (rem_reg >= red_cmp)
                begin
                    rem_reg <= rem_reg - red_cmp;
                    n_reg   <= n_reg | (6'd1 << cnt_reg);
                end
                cnt_reg <= cnt_reg - 5'd1;
            end
            S_EXPW:  if (cdone) e_reg <= e_sum[CW-1] ? 32'd0 : e_sum[31:0];
            S_NUM:   num_reg <= num_next;
            S_DCHK:  d_reg <= cos_pos ? prod_reg[63:30] : 34'd0;
            S_DCHK2:
            begin
                if (d_reg == '0 || num_reg >= {{(NW-42){1'b0}}, d_reg, 8'd0})
                    t_reg <= TIME_MAX;
                rem_reg <= 36'(num_reg >> 8);
                dl_reg  <= {num_reg[7:0], 24'd0};
                cnt_reg <= '0;
            end
            S_DIV:
            begin
                rem_reg <= div_ge ? div_sh - {2'b00, d_reg} : div_sh;
                t_reg   <= {t_reg[30:0], div_ge};
                dl_reg  <= {dl_reg[30:0], 1'b0};
                cnt_reg <= cnt_reg + 5'd1;
            end
            S_TT:    vt_reg <= prod_reg[40+FRAC_BITS:FRAC_BITS];
            S_GW1:   whi_reg <= w_full[47:32];
            S_GW2:   glo_reg <= prod_reg;
            S_UPD:   dy_reg <= dy_now;
            S_AIM:
            begin
                aim_reg  <= aim_sat;
                conv_reg <= conv_now;
                if (!(conv_now || round_reg == lim))
                    round_reg <= round_reg + ROUND_W'(1);
            end
            S_DONE:
            begin
                if (!out_valid_reg || solution.ready)
                begin
                    ox_reg      <= x_reg;
                    oy_reg      <= y_reg;
                    oaim_reg    <= aim_reg;
                    ot_reg      <= t_reg;
                    oconv_reg   <= conv_reg;
                    orounds_reg <= round_reg;
                end
            end
            default: ;
        endcase
    end

    assign solution.valid       = out_valid_reg;
    assign solution.out_x       = ox_reg;
    assign solution.out_y       = oy_reg;
    assign solution.aim_height  = oaim_reg;
    assign solution.flight_time = ot_reg;
    assign solution.converged   = oconv_reg;
    assign solution.rounds_used = orounds_reg;

`ifndef SYNTHESIS
    // an accepted target always starts the range calculation
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> (state_reg == S_SQA))
        else $error("accepted target did not start the solve");

    // the CORDIC engine only finishes while the sequencer waits for it
    a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
        cdone |-> (state_reg == S_ATANW || state_reg == S_SCW || state_reg == S_EXPW))
        else $error("CORDIC result arrived outside a wait state");

    // a delivered solution has used at least one round
    a_rounds_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        solution.valid |-> (solution.rounds_used != '0))
        else $error("solution reports zero rounds");

    // a non-converged solution has run to the round limit
    a_limit_hit: assert property (@(posedge clk) disable iff (!rst_n)
        (solution.valid && !solution.converged) |-> (solution.rounds_used == lim))
        else $error("solution stopped early without converging");
`endif

endmodule

// ===== hw/rtl/dbah_cordic.sv =====
// dbah_cordic: iterative CORDIC engine, one micro-rotation per cycle.
// Circular vectoring, circular rotation and hyperbolic rotation; uses dbah_pkg.
module dbah_cordic #(
    parameter int STAGES = dbah_pkg::CORDIC_STAGES_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  dbah_pkg::cordic_ctrl_t         ctrl,
    input  logic signed [dbah_pkg::CW-1:0] x0,
    input  logic signed [dbah_pkg::CW-1:0] y0,
    input  logic signed [dbah_pkg::CW-1:0] z0,
    output logic                           done,
    output logic signed [dbah_pkg::CW-1:0] x,
    output logic signed [dbah_pkg::CW-1:0] y,
    output logic signed [dbah_pkg::CW-1:0] z
);
    import dbah_pkg::*;

    logic                 busy_reg, done_reg, rep_reg;
    logic [1:0]           mode_reg;
    logic [5:0]           idx_reg;
    logic signed [CW-1:0] x_reg, y_reg, z_reg;

    logic signed [CW-1:0] xs, ys, ang, nx, ny, nz;
    logic                 hyp, dir, repeat_now, last;

    // one micro-rotation
    always_comb
    begin
        hyp = (mode_reg == CM_HYP);
        xs  = x_reg >>> idx_reg;
        ys  = y_reg >>> idx_reg;
        if (hyp)
            ang = $signed({{(CW-32){1'b0}}, hyp_angle(idx_reg)});
        else
            ang = $signed({{(CW-32){1'b0}}, CIRC_TAB[idx_reg[4:0]]});
        dir = (mode_reg == CM_VEC) ? y_reg[CW-1] : !z_reg[CW-1];
        if (hyp)
        begin
            if (!z_reg[CW-1])
            begin
                nx = x_reg + ys;  ny = y_reg + xs;  nz = z_reg - ang;
            end
            else
            begin
                nx = x_reg - ys;  ny = y_reg - xs;  nz = z_reg + ang;
            end
        end
        else if (dir)
        begin
            nx = x_reg - ys;  ny = y_reg + xs;  nz = z_reg - ang;
        end
        else
        begin
            nx = x_reg + ys;  ny = y_reg - xs;  nz = z_reg + ang;
        end
        // hyperbolic steps 4 and 13 run twice
        repeat_now = hyp && !rep_reg && (idx_reg == 6'd4 || idx_reg == 6'd13);
        last = !repeat_now && (idx_reg == (hyp ? 6'(STAGES) : 6'(STAGES - 1)));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= busy_reg && last;
            if (ctrl.start)
                busy_reg <= 1'b1;
            else if (last)
                busy_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            mode_reg <= ctrl.mode;
            idx_reg  <= (ctrl.mode == CM_HYP) ? 6'd1 : 6'd0;
            rep_reg  <= 1'b0;
            x_reg    <= x0;
            y_reg    <= y0;
            z_reg    <= z0;
        end
        else if (busy_reg)
        begin
            x_reg   <= nx;
            y_reg   <= ny;
            z_reg   <= nz;
            rep_reg <= repeat_now;
            if (!repeat_now && !last)
                idx_reg <= idx_reg + 6'd1;
        end
    end

    assign done = done_reg;
    assign x    = x_reg;
    assign y    = y_reg;
    assign z    = z_reg;
endmodule

// ===== tb/tb.sv =====
// tb: self-checking bench for the drag-compensated aim-height solver.
// Uses dbah_pkg, dbah_in_if, dbah_out_if and drag_ballistic_aim_height_solver.
// Targets are predicted in-bench at acceptance and checked in order at the output.
`timescale 1ns / 100ps

module tb;
    import dbah_pkg::*;

    localparam int          FB        = FRAC_BITS;
    localparam int          STAGES    = CORDIC_STAGES_DEF;
    localparam int          WDOG_MAX  = 200000;
    localparam int          N_RANDOM  = 57;   // per random phase
    localparam longint      TERM_CAP  = 64'sd1 <<< 61;
    localparam longint unsigned T_SAT = 64'hFFFF_FFFF;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] h;
    } target_t;

    typedef struct {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] aim;
        logic        [31:0]        ft;
        logic                      conv;
        logic        [ROUND_W-1:0] rounds;
    } solution_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dbah_in_if  tgt_if ();
    dbah_out_if sol_if ();

    drag_ballistic_aim_height_solver u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .target    (tgt_if),
        .solution  (sol_if)
    );

    // shadow of the configuration registers
    longint unsigned speed_r, drag_r, grav_r, tol_r, rounds_r;

    target_t   target_q[$];
    solution_t aim_q[$];
    int        src_idle_pct;
    int        snk_stall_pct;
    bit        send_hold;
    int        long_stall;
    int        n_errors;
    int        wdog;

    // clock
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------- predictor ----------------
    function automatic longint asr(longint v, int s);
        if (s > 63)
            s = 63;
        return v >>> s;
    endfunction

    function automatic longint unsigned mul_sat(longint unsigned a, longint unsigned b);
        if (a != 0 && b > 64'hFFFF_FFFF_FFFF_FFFF / a)
            return 64'hFFFF_FFFF_FFFF_FFFF;
        return a * b;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned res = 0;
        longint unsigned bt = 64'd1 << 62;
        while (bt > v)
            bt >>= 2;
        while (bt != 0)
        begin
            if (v >= res + bt)
            begin
                v -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic longint angle_of(longint y, longint x);
        longint z = 0;
        longint nx;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            if (y < 0)
            begin
                nx = x - asr(y, i);
                y  = y + asr(x, i);
                z -= longint'(CIRC_TAB[i]);
            end
            else
            begin
                nx = x + asr(y, i);
                y  = y - asr(x, i);
                z += longint'(CIRC_TAB[i]);
            end
            x = nx;
        end
        return z;
    endfunction

    function automatic void rotate_unit(longint z, output longint c, output longint s);
        longint x = longint'(CIRC_KINV);
        longint y = 0;
        longint nx;
        for (int i = 0; i < STAGES && i < 32; i++)
        begin
            if (z >= 0)
            begin
                nx = x - asr(y, i);
                y  = y + asr(x, i);
                z -= longint'(CIRC_TAB[i]);
            end
            else
            begin
                nx = x + asr(y, i);
                y  = y - asr(x, i);
                z += longint'(CIRC_TAB[i]);
            end
            x = nx;
        end
        c = x;
        s = y;
    endfunction

    // e^z for z in [0, ln2), Q2.30
    function automatic longint exp_frac(longint z);
        longint x = longint'(HYP_KINV);
        longint y = 0;
        longint nx;
        longint th;
        int     reps;
        for (int i = 1; i <= STAGES; i++)
        begin
            if (i <= 10)
                th = longint'(HYP_TAB[i]);
            else if (i <= 30)
                th = 64'sd1 <<< (30 - i);
            else
                th = 0;
            reps = (i == 4 || i == 13) ? 2 : 1;
            for (int rp = 0; rp < reps; rp++)
            begin
                if (z >= 0)
                begin
                    nx = x + asr(y, i);
                    y  = y + asr(x, i);
                    z -= th;
                end
                else
                begin
                    nx = x - asr(y, i);
                    y  = y - asr(x, i);
                    z += th;
                end
                x = nx;
            end
        end
        return x + y;
    endfunction

    function automatic longint unsigned time_of_flight(longint unsigned r, longint cosv);
        longint unsigned ln2 = longint'(LN2_Q30);
        longint unsigned u30, n, d, q, t;
        longint          e, num;
        int              sh;
        u30 = (drag_r * r) >> (FB - 14);
        n   = u30 / ln2;
        if (n > 32)
            return T_SAT;
        e = exp_frac(longint'(u30 - n * ln2));
        if (e < 0)
            e = 0;
        sh  = int'(n) + FB;
        num = (sh >= 30) ? (e <<< (sh - 30)) : (e >>> (30 - sh));
        num -= 64'sd1 <<< FB;
        if (num < 0)
            num = 0;
        d = (cosv > 0) ? ((drag_r * speed_r * longint'(cosv)) >> 30) : 0;
        if (d == 0)
            return T_SAT;
        q = longint'(num) / d;
        if (q >= 256)
            return T_SAT;
        t = (q << 24) + (((longint'(num) % d) << 24) / d);
        return (t > T_SAT) ? T_SAT : t;
    endfunction

    function automatic solution_t solve_aim(target_t tg);
        solution_t       sol;
        longint          x, y, h, aim, ang, c, s, vt, gt, reach, dy;
        longint unsigned ax, ay, r, lim, t, m, ady, used;
        bit              conv;
        x    = longint'(tg.x);
        y    = longint'(tg.y);
        h    = longint'(tg.h);
        ax   = (x < 0) ? -x : x;
        ay   = (y < 0) ? -y : y;
        r    = int_sqrt(ax * ax + ay * ay);
        lim  = (rounds_r == 0) ? 1 : rounds_r;
        aim  = h;
        t    = 0;
        used = 0;
        conv = 1'b0;
        for (longint unsigned k = 1; k <= lim; k++)
        begin
            ang = angle_of(aim, longint'(r));
            rotate_unit(ang, c, s);
            t  = time_of_flight(r, c);
            m  = speed_r * longint'((s < 0) ? -s : s);
            m  = m >> (38 - FB);
            m  = mul_sat(m, t) >> FB;
            vt = (m > TERM_CAP) ? TERM_CAP : longint'(m);
            m  = mul_sat(grav_r, (t * t) >> FB) >> 9;
            gt = (m > TERM_CAP) ? TERM_CAP : longint'(m);
            reach = ((s < 0) ? -vt : vt) - gt;
            dy    = h - reach;
            aim  += dy;
            if (aim > 64'sd2147483647)
                aim = 64'sd2147483647;
            if (aim < -64'sd2147483648)
                aim = -64'sd2147483648;
            used = k;
            ady  = (dy < 0) ? -dy : dy;
            if (ady < tol_r)
            begin
                conv = 1'b1;
                break;
            end
        end
        sol.x      = tg.x;
        sol.y      = tg.y;
        sol.aim    = aim[31:0];
        sol.ft     = t[31:0];
        sol.conv   = conv;
        sol.rounds = used[ROUND_W-1:0];
        return sol;
    endfunction

    // ---------------- driver ----------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_if.valid         <= 1'b0;
            tgt_if.target_x      <= '0;
            tgt_if.target_y      <= '0;
            tgt_if.target_height <= '0;
        end
        else
        begin
            if (tgt_if.valid && tgt_if.ready)
            begin
                aim_q.insert(aim_q.size(), solve_aim(target_q.pop_front()));
            end
            // hold an offered item until it is taken
            if (!tgt_if.valid || tgt_if.ready)
            begin
                if (target_q.size() != 0 && !send_hold
                    && $urandom_range(99) >= src_idle_pct)
                begin
                    tgt_if.valid         <= 1'b1;
                    tgt_if.target_x      <= target_q[0].x;
                    tgt_if.target_y      <= target_q[0].y;
                    tgt_if.target_height <= target_q[0].h;
                end
                else
                    tgt_if.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge clk or negedge rst_n)
    begin
        solution_t want;
        if (!rst_n)
            sol_if.ready <= 1'b0;
        else
        begin
            if (sol_if.valid && sol_if.ready)
            begin
                if (aim_q.size() == 0)
                begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("ERROR: unexpected solution item x=%0d y=%0d",
                                 sol_if.out_x, sol_if.out_y);
                end
                else
                begin
                    want = aim_q.pop_front();
                    if (sol_if.out_x !== want.x || sol_if.out_y !== want.y
                        || sol_if.aim_height !== want.aim || sol_if.flight_time !== want.ft
                        || sol_if.converged !== want.conv
                        || sol_if.rounds_used !== want.rounds)
                    begin
                        n_errors++;
                        if (n_errors <= 10)
                        begin
                            $display("ERROR: exp x=%0d y=%0d aim=%0d t=%0d conv=%0d rnd=%0d",
                                     want.x, want.y, want.aim, want.ft, want.conv,
                                     want.rounds);
                            $display("       got x=%0d y=%0d aim=%0d t=%0d conv=%0d rnd=%0d",
                                     sol_if.out_x, sol_if.out_y, sol_if.aim_height,
                                     sol_if.flight_time, sol_if.converged,
                                     sol_if.rounds_used);
                        end
                    end
                end
            end
            // long hold-off first, then random stalls
            if (long_stall > 0)
            begin
                long_stall   = long_stall - 1;
                sol_if.ready <= 1'b0;
            end
            else
                sol_if.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk)
    begin
        if (!rst_n || (tgt_if.valid && tgt_if.ready) || (sol_if.valid && sol_if.ready))
            wdog <= 0;
        else
        begin
            wdog <= wdog + 1;
            if (wdog >= WDOG_MAX)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_SPEED:  speed_r  = val;
            REG_DRAG:   drag_r   = val;
            REG_GRAV:   grav_r   = val;
            REG_TOL:    tol_r    = val;
            REG_ROUNDS: rounds_r = val[ROUND_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all(logic [15:0] sp, logic [15:0] dr, logic [15:0] gr,
                           logic [15:0] tl, logic [15:0] rn);
        write_reg(REG_SPEED, sp);
        write_reg(REG_DRAG, dr);
        write_reg(REG_GRAV, gr);
        write_reg(REG_TOL, tl);
        write_reg(REG_ROUNDS, rn);
    endtask

    task automatic add_target(longint x, longint y, longint h);
        target_t tg;
        tg.x = x[31:0];
        tg.y = y[31:0];
        tg.h = h[31:0];
        @(negedge clk);
        target_q.insert(target_q.size(), tg);
    endtask

    task automatic drain();
        while (target_q.size() != 0 || aim_q.size() != 0 || tgt_if.valid)
            @(posedge clk);
    endtask

    // mostly plausible ranges, sometimes the whole 32-bit field
    task automatic add_random_target();
        longint x, y, h;
        if ($urandom_range(9) == 0)
        begin
            x = longint'(signed'($urandom()));
            y = longint'(signed'($urandom()));
            h = longint'(signed'($urandom()));
        end
        else
        begin
            x = longint'($urandom_range(60 << 16)) - (30 << 16);
            y = longint'($urandom_range(60 << 16)) - (30 << 16);
            h = longint'($urandom_range(12 << 16)) - (6 << 16);
        end
        add_target(x, y, h);
    endtask

    task automatic random_phase(int idle_pct, int stall_pct);
        int rn;
        drain();
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        rn = ($urandom_range(7) == 0) ? $urandom_range(63) : $urandom_range(1, 20);
        set_all(16'($urandom_range(1000, 65535)), 16'($urandom_range(1, 4000)),
                16'($urandom_range(65535)), 16'($urandom_range(4000)), 16'(rn));
        for (int i = 0; i < N_RANDOM; i++)
            add_random_target();
    endtask

    initial
    begin
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        send_hold     = 1'b0;
        long_stall    = 0;
        n_errors      = 0;
        wdog          = 0;
        speed_r       = SPEED_RST;
        drag_r        = DRAG_RST;
        grav_r        = GRAV_RST;
        tol_r         = TOL_RST;
        rounds_r      = ROUNDS_RST;
        rst_n         = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // directed: reset settings, field extremes and the origin
        add_target(0, 0, 0);
        add_target(0, 0, 5 << 16);
        add_target(10 << 16, 0, 0);
        add_target(-(20 << 16), 15 << 16, -(3 << 16));
        add_target(64'sh7FFF_FFFF, 64'sh7FFF_FFFF, 64'sh7FFF_FFFF);
        add_target(-64'sh8000_0000, -64'sh8000_0000, -64'sh8000_0000);
        add_target(5 << 16, 5 << 16, 64'sh7FFF_FFFF);
        add_target(5 << 16, -(5 << 16), -64'sh8000_0000);
        drain();

        // zero speed: no divisor; ignored indexes and a masked round count
        set_all(16'd0, 16'd655, 16'd2509, 16'd66, 16'hFFC3);
        write_reg(3'd5, 16'hFFFF);
        write_reg(3'd7, 16'h1234);
        add_target(8 << 16, 0, 1 << 16);
        add_target(0, 0, 0);
        drain();

        // strong drag, zero round limit: huge exponent, one round
        set_all(16'd3840, 16'hFFFF, 16'd2509, 16'd66, 16'd0);
        add_target(30 << 16, 30 << 16, 1 << 16);
        add_target(1 << 16, 0, 0);
        add_target(1, 1, -1);
        drain();

        // every register at its maximum
        set_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd63);
        add_target(3 << 16, 4 << 16, 1 << 16);
        add_target(-(12 << 16), 0, -(2 << 16));
        drain();

        // minimum drag and gravity, zero tolerance: runs to the limit
        set_all(16'd1, 16'd1, 16'd0, 16'd0, 16'd63);
        add_target(20 << 16, 0, 2 << 16);
        add_target(0, -(7 << 16), -(1 << 16));
        drain();

        // random phases; the receiver holds off long in the first one
        random_phase(0, 0);
        @(negedge clk);
        long_stall = 20000;
        random_phase(48, 0);
        // sender pauses part-way through until every accepted item has been delivered
        repeat (N_RANDOM / 2) @(posedge clk);
        send_hold = 1'b1;
        while (aim_q.size() != 0)
            @(posedge clk);
        send_hold = 1'b0;
        random_phase(0, 48);
        random_phase(22, 22);
        random_phase(0, 0);

        drain();
        repeat (400) @(posedge clk);
        if (n_errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
